[hw/rtl/qtok_pkg.sv]
// Package with the word types, result kinds and register indexes of the quote-aware tokenizer.
`timescale 1ns / 1ps

package qtok_pkg;

  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_END_TOKEN  = 2'd1;
  localparam logic [1:0] KIND_END_STRING = 2'd2;

  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_DOUBLE = 2'd1;
  localparam logic [1:0] QM_SINGLE = 2'd2;

  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  localparam logic [2:0] REG_DELIM_0 = 3'd0;
  localparam logic [2:0] REG_DELIM_1 = 3'd1;
  localparam logic [2:0] REG_DELIM_2 = 3'd2;
  localparam logic [2:0] REG_DELIM_3 = 3'd3;
  localparam logic [2:0] REG_COMMENT = 3'd4;

  localparam int unsigned RES_SLOTS = 3;

  localparam logic [63:0] DELIM_0_RESET = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       run_last;
  } out_t;

endpackage

[hw/rtl/quote_aware_field_tokenizer_core.sv]
// Top level of the quote-aware field tokenizer with comment character.
`timescale 1ns / 1ps

// The input channel takes one text byte per word (in_valid/in_ready/in_data), with has_byte
// clear only for a bare end-of-string word. The output channel (out_valid/out_ready/out_data)
// delivers token bytes, end-of-token marks and an end-of-string mark, with run_last set on the
// last result word of each input word. An input word is decoded in the cycle it is accepted and
// its zero to three result words are held in a three-slot result holder. The holder feeds an
// output register, so each result passes through the holder and then the output register. While
// the receiver takes every word, the output moves one word per cycle and input words with at
// most one result stream at one word per cycle. A new word is taken as soon as the holder is
// empty or is handing over its last entry, even while the output register holds a word that
// the receiver has not yet taken. When the receiver stalls, the output register holds its word,
// the holder fills and in_ready drops. The configuration port writes a register at cfg_we; the
// user must use it only while the block is idle, which the block itself does not enforce. Reset
// clears the quote, token and comment state, empties the holder and output register, and loads
// the register defaults: space as the only delimiter and comments disabled.
module quote_aware_field_tokenizer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qtok_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output qtok_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  logic [255:0]   delim_mask;
  logic [7:0]     comment_char;

  logic [1:0]     quote_mode;
  logic           token_open;
  logic           discarding;
  logic [1:0]     quote_mode_next;
  logic           token_open_next;
  logic           discarding_next;

  qtok_pkg::out_t hold [qtok_pkg::RES_SLOTS];
  logic [1:0]     hcnt;
  qtok_pkg::out_t res_next [qtok_pkg::RES_SLOTS];
  logic [1:0]     res_cnt;

  logic           accept;
  logic           out_free;
  logic           move;

  logic [1:0]     qsel;
  logic           is_comment;
  logic           is_delim;
  logic           emit0;
  qtok_pkg::out_t word0;
  logic           emit1;

  assign out_free = !out_valid || out_ready;
  assign move     = out_free && (hcnt != 2'd0);
  assign in_ready = (hcnt == 2'd0) || (move && (hcnt == 2'd1));
  assign accept   = in_valid && in_ready;

  always_comb begin
    qsel = (in_data.text_byte == qtok_pkg::CHAR_DQUOTE) ? qtok_pkg::QM_DOUBLE :
           (in_data.text_byte == qtok_pkg::CHAR_SQUOTE) ? qtok_pkg::QM_SINGLE :
           qtok_pkg::QM_NONE;
    is_comment = (comment_char != qtok_pkg::CHAR_NUL) &&
                 (in_data.text_byte == comment_char) && (quote_mode == qtok_pkg::QM_NONE);
    is_delim = delim_mask[in_data.text_byte];

    quote_mode_next = quote_mode;
    token_open_next = token_open;
    discarding_next = discarding;
    emit0 = 1'b0;
    word0 = '{kind: qtok_pkg::KIND_BYTE, value: in_data.text_byte,
              run_last: !in_data.string_end};

    if (in_data.has_byte && !discarding) begin
      if (is_comment) begin
        discarding_next = 1'b1;
      end else if (qsel != qtok_pkg::QM_NONE) begin
        if (quote_mode == qtok_pkg::QM_NONE) begin
          quote_mode_next = qsel;
          token_open_next = 1'b1;
        end else if (quote_mode == qsel) begin
          quote_mode_next = qtok_pkg::QM_NONE;
        end else begin
          emit0 = 1'b1;
        end
      end else if ((quote_mode == qtok_pkg::QM_NONE) && is_delim) begin
        if (token_open) begin
          emit0 = 1'b1;
          word0.kind = qtok_pkg::KIND_END_TOKEN;
          word0.value = 8'd0;
          token_open_next = 1'b0;
        end
      end else begin
        emit0 = 1'b1;
        token_open_next = 1'b1;
      end
    end

    emit1 = in_data.string_end && token_open_next;

    // Pack the results of this word into the lowest slots in output order.
    for (int i = 0; i < qtok_pkg::RES_SLOTS; i++) begin
      res_next[i] = '{kind: qtok_pkg::KIND_END_STRING, value: 8'd0, run_last: 1'b1};
    end
    res_cnt = 2'd0;
    if (emit0) begin
      res_next[res_cnt] = word0;
      res_cnt = res_cnt + 2'd1;
    end
    if (emit1) begin
      res_next[res_cnt] = '{kind: qtok_pkg::KIND_END_TOKEN, value: 8'd0, run_last: 1'b0};
      res_cnt = res_cnt + 2'd1;
    end
    if (in_data.string_end) begin
      res_next[res_cnt] = '{kind: qtok_pkg::KIND_END_STRING, value: 8'd0, run_last: 1'b1};
      res_cnt = res_cnt + 2'd1;
      quote_mode_next = qtok_pkg::QM_NONE;
      token_open_next = 1'b0;
      discarding_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_mask   <= {192'd0, qtok_pkg::DELIM_0_RESET};
      comment_char <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        qtok_pkg::REG_DELIM_0: delim_mask[63:0]    <= cfg_data;
        qtok_pkg::REG_DELIM_1: delim_mask[127:64]  <= cfg_data;
        qtok_pkg::REG_DELIM_2: delim_mask[191:128] <= cfg_data;
        qtok_pkg::REG_DELIM_3: delim_mask[255:192] <= cfg_data;
        qtok_pkg::REG_COMMENT: comment_char        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= qtok_pkg::QM_NONE;
      token_open <= 1'b0;
      discarding <= 1'b0;
    end else if (accept) begin
      quote_mode <= quote_mode_next;
      token_open <= token_open_next;
      discarding <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt <= 2'd0;
    end else if (accept) begin
      hcnt <= res_cnt;
    end else if (move) begin
      hcnt <= hcnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < qtok_pkg::RES_SLOTS; i++) begin
        hold[i] <= res_next[i];
      end
    end else if (move) begin
      hold[0] <= hold[1];
      hold[1] <= hold[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= hold[0];
    end
  end

`ifndef SYNTHESIS
  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.string_end |=>
      quote_mode == qtok_pkg::QM_NONE && !token_open && !discarding)
    else $error("string end did not return the tokenizer state to idle");

  a_comment_outside_quotes: assert property (@(posedge clk) disable iff (rst)
    discarding |-> quote_mode == qtok_pkg::QM_NONE)
    else $error("comment discard active inside a quoted section");

  a_end_string_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == qtok_pkg::KIND_END_STRING |-> out_data.run_last)
    else $error("end-of-string word not marked as last result");

  a_mark_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != qtok_pkg::KIND_BYTE |-> out_data.value == 8'd0)
    else $error("mark word carries a nonzero value");
`endif

endmodule
